/* hw/rtl/assert_macros.svh */
// Assertion macros used by the lock-order cycle detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked on every edge.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lockord_pkg.sv */
// Package for the lock-order cycle detector: request codes and defaults.
package lockord_pkg;

  localparam int NUM_RESOURCES_DEF = 32;

  localparam int REQ_TYPE_W = 2;
  localparam int RES_ID_W   = 5;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 8;

  localparam logic [REQ_TYPE_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CHECK   = 2'd2;

endpackage

/* hw/rtl/lockord_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module lockord_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lock_order_cycle_detector.sv */
// Top level of the lock-order cycle detector (held set, edge matrix, DFS engine).
//
// Each input transaction is a request: acquire, release or check, naming a
// resource index. Acquire adds a lock-order edge from every held resource to
// the named one (a resource acquired while already held gets a self-edge) and
// then marks it held; release clears the held mark; check runs a depth-first
// search over the lock-order graph and returns one output transaction whose
// bit is 1 when the graph holds a cycle. Acquire and release return nothing,
// nor does request type 3; an out-of-range index drops an acquire or release.
// After reset the edge memory is cleared one row per cycle, and s_tready
// stays low until the clear is done. Acquire is a read-modify-write sweep
// over all rows of the edge memory. A check steps through the root slots,
// loads a root's row, pushes (step, row load), passes over edges, pops back
// to a parent (step, stack read, row reload), pops a root and then hands the
// flag to the output register; the single read port of the edge memory sets
// its pace. A finished check result waits in the output register while the
// next request is already taken.
`include "assert_macros.svh"

module lock_order_cycle_detector #(
  parameter int NUM_RESOURCES = lockord_pkg::NUM_RESOURCES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [1:0] req_type, [6:2] resource_id, [7] zero
  input  logic [lockord_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] cycle_found, [7:1] zero
  output logic [lockord_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int IW = $clog2(NUM_RESOURCES);      // resource index
  localparam int DW = $clog2(NUM_RESOURCES + 1);  // counts 0..N
  localparam int CW = DW;                         // stack cursor
  localparam int SW = IW + CW;                    // stack entry

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_ACQ  = 8'b00000100,
    S_ROOT = 8'b00001000,
    S_LOAD = 8'b00010000,
    S_STEP = 8'b00100000,
    S_POP  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state;

  // input fields
  logic [lockord_pkg::REQ_TYPE_W-1:0] req_type;
  logic [lockord_pkg::RES_ID_W-1:0]   resource_id;
  logic                               id_ok;

  // control and search state
  logic [NUM_RESOURCES-1:0] held;
  logic [NUM_RESOURCES-1:0] visited;
  logic [NUM_RESOURCES-1:0] on_stack;
  logic [DW-1:0]            cnt;       // clear row / acquire sweep row
  logic                     wr_vld;    // row read last cycle, write now
  logic [IW-1:0]            wr_addr;
  logic [IW-1:0]            req_id;
  logic [DW-1:0]            root;
  logic [DW-1:0]            depth;
  logic [IW-1:0]            top_node;
  logic [CW-1:0]            top_cur;
  logic [NUM_RESOURCES-1:0] row;       // edge row of top_node
  logic                     done_flag;
  logic                     cycle_res;

  // next-edge search over the current row
  logic          found;
  logic [IW-1:0] nxt;
  logic [CW-1:0] nxt_cur;

  // memory ports
  logic                     edge_we;
  logic [IW-1:0]            edge_waddr;
  logic [NUM_RESOURCES-1:0] edge_wdata;
  logic [IW-1:0]            edge_raddr;
  logic [NUM_RESOURCES-1:0] edge_rdata;
  logic                     stk_we;
  logic [IW-1:0]            stk_waddr;
  logic [SW-1:0]            stk_wdata;
  logic [IW-1:0]            stk_raddr;
  logic [SW-1:0]            stk_rdata;
  logic [IW-1:0]            stk_node_rd;
  logic [CW-1:0]            stk_cur_rd;
  logic                     push;

  assign req_type    = s_tdata[1:0];
  assign resource_id = s_tdata[6:2];
  assign id_ok       = int'(resource_id) < NUM_RESOURCES;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{(lockord_pkg::M_TDATA_W-1){1'b0}}, cycle_res};

  assign stk_node_rd = stk_rdata[SW-1:CW];
  assign stk_cur_rd  = stk_rdata[CW-1:0];

  // first set bit of the row at or above the cursor
  always_comb begin
    found = 1'b0;
    nxt   = '0;
    for (int j = NUM_RESOURCES - 1; j >= 0; j--) begin
      if (row[j] && (j >= int'(top_cur))) begin
        found = 1'b1;
        nxt   = IW'(j);
      end
    end
  end

  assign nxt_cur = CW'(nxt) + CW'(1);
  assign push    = (state == S_STEP) && found && !on_stack[nxt] && !visited[nxt] &&
                   (depth < DW'(NUM_RESOURCES));

  always_comb begin
    case (state)
      S_ACQ:   edge_raddr = cnt[IW-1:0];
      S_ROOT:  edge_raddr = root[IW-1:0];
      S_STEP:  edge_raddr = nxt;
      S_POP:   edge_raddr = stk_node_rd;
      default: edge_raddr = top_node;
    endcase
  end

  // clearing pass writes zero rows; acquire writes back held rows
  assign edge_we    = (state == S_CLR) || ((state == S_ACQ) && wr_vld && held[wr_addr]);
  assign edge_waddr = (state == S_CLR) ? cnt[IW-1:0] : wr_addr;
  assign edge_wdata = (state == S_CLR) ? '0 : (edge_rdata | (NUM_RESOURCES'(1) << req_id));

  // stack keeps the levels below the top; top lives in top_node/top_cur
  assign stk_we    = push;
  assign stk_waddr = IW'(depth - DW'(1));
  assign stk_wdata = {top_node, nxt_cur};
  assign stk_raddr = IW'(depth - DW'(2));

  lockord_ram #(
    .WIDTH (NUM_RESOURCES),
    .DEPTH (NUM_RESOURCES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  lockord_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_RESOURCES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cnt      <= '0;
      held     <= '0;
      visited  <= '0;
      on_stack <= '0;
      wr_vld   <= 1'b0;
      depth    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_DONE drives m_tvalid itself
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (cnt == DW'(NUM_RESOURCES - 1)) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + DW'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            case (req_type)
              lockord_pkg::REQ_ACQUIRE: begin
                if (id_ok) begin
                  req_id <= IW'(resource_id);
                  cnt    <= '0;
                  wr_vld <= 1'b0;
                  state  <= S_ACQ;
                end
              end
              lockord_pkg::REQ_RELEASE: begin
                if (id_ok) begin
                  held[IW'(resource_id)] <= 1'b0;
                end
              end
              lockord_pkg::REQ_CHECK: begin
                visited  <= '0;
                on_stack <= '0;
                root     <= '0;
                state    <= S_ROOT;
              end
              default: ;
            endcase
          end
        end
        S_ACQ: begin
          wr_vld  <= cnt < DW'(NUM_RESOURCES);
          wr_addr <= cnt[IW-1:0];
          if (cnt == DW'(NUM_RESOURCES)) begin
            // last row is written this cycle; held set updates after the sweep
            held[req_id] <= 1'b1;
            wr_vld       <= 1'b0;
            state        <= S_IDLE;
          end else begin
            cnt <= cnt + DW'(1);
          end
        end
        S_ROOT: begin
          if (root == DW'(NUM_RESOURCES)) begin
            done_flag <= 1'b0;
            state     <= S_DONE;
          end else if (visited[root[IW-1:0]]) begin
            root <= root + DW'(1);
          end else begin
            top_node                <= root[IW-1:0];
            top_cur                 <= '0;
            depth                   <= DW'(1);
            visited[root[IW-1:0]]  <= 1'b1;
            on_stack[root[IW-1:0]] <= 1'b1;
            state                   <= S_LOAD;
          end
        end
        S_LOAD: begin
          row   <= edge_rdata;
          state <= S_STEP;
        end
        S_STEP: begin
          if (!found) begin
            on_stack[top_node] <= 1'b0;
            depth              <= depth - DW'(1);
            if (depth == DW'(1)) begin
              root  <= root + DW'(1);
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end else if (on_stack[nxt]) begin
            done_flag <= 1'b1;
            state     <= S_DONE;
          end else if (push) begin
            top_node      <= nxt;
            top_cur       <= '0;
            depth         <= depth + DW'(1);
            visited[nxt]  <= 1'b1;
            on_stack[nxt] <= 1'b1;
            state         <= S_LOAD;
          end else begin
            top_cur <= nxt_cur;
          end
        end
        S_POP: begin
          top_node <= stk_node_rd;
          top_cur  <= stk_cur_rd;
          state    <= S_LOAD;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            cycle_res <= done_flag;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // on-stack marks are always a subset of visited marks
  `ASSERT_CLK_RST(a_onstack_visited, clk, rst, (on_stack & ~visited) == '0, "on-stack mark without visited mark")
  // every stack level holds exactly one on-stack node
  `ASSERT_CLK_RST(a_depth_marks, clk, rst, (state == S_STEP) |-> ($countones(on_stack) == int'(depth)), "stack depth disagrees with on-stack marks")
  // the search never runs with an empty stack
  `ASSERT_CLK_RST(a_depth_nonzero, clk, rst, ((state == S_STEP) || (state == S_LOAD)) |-> (depth != '0), "search step with empty stack")
  // an acquire sweep ends with the resource marked held
  `ASSERT_CLK_RST(a_acq_held, clk, rst, ((state == S_ACQ) && (cnt == DW'(NUM_RESOURCES))) |=> held[req_id], "acquire did not set held mark")

endmodule
